@@ sv/cps_pkg.sv @@
`default_nettype none
package cps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int ID_W      = 4;
    localparam int CNT_W     = 5;

    // configuration register indexes
    localparam logic [1:0] CFG_POLICY     = 2'd0;
    localparam logic [1:0] CFG_QUANTUM    = 2'd1;
    localparam logic [1:0] CFG_TICK_LIMIT = 2'd2;

    // scheduling policies
    localparam logic [2:0] POL_FCFS      = 3'd0;
    localparam logic [2:0] POL_SJF       = 3'd1;
    localparam logic [2:0] POL_SJF_PRE   = 3'd2;
    localparam logic [2:0] POL_PRIO      = 3'd3;
    localparam logic [2:0] POL_PRIO_PRE  = 3'd4;
    localparam logic [2:0] POL_RR        = 3'd5;
    localparam logic [2:0] POL_LONG_IO   = 3'd6;

    // input item kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // ready queue ordering keys
    localparam logic [1:0] KEY_FCFS  = 2'd0;
    localparam logic [1:0] KEY_BURST = 2'd1;
    localparam logic [1:0] KEY_PRIO  = 2'd2;
    localparam logic [1:0] KEY_IO    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADMIT,
        ST_IO_RD,
        ST_IO_WR,
        ST_PICK,
        ST_SORT,
        ST_RUN_RD,
        ST_RUN_WR,
        ST_CHG_RD,
        ST_CHG_WR,
        ST_FIN
    } state_t;

    // per-process record held in the record memory
    typedef struct packed {
        logic [7:0]  cpu;
        logic [7:0]  io;
        logic [7:0]  trig;
        logic [7:0]  prio;
        logic [15:0] wait_cnt;
        logic [15:0] turn_cnt;
    } rec_t;

    // ready queue entry with a snapshot of its ordering keys
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [7:0]      cpu;
        logic [7:0]      prio;
        logic [7:0]      io;
    } rdy_t;

    // job queue entry
    typedef struct packed {
        logic [7:0] arr;
        rdy_t       key;
    } job_t;

    // one result item
    typedef struct packed {
        logic [15:0]     tick_time;
        logic            run_valid;
        logic [ID_W-1:0] run_id;
        logic            done_valid;
        logic [ID_W-1:0] done_id;
        logic [15:0]     done_turnaround;
        logic [15:0]     done_waiting;
        logic            all_done;
    } result_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        begin
            return (v == 16'hFFFF) ? v : v + 16'd1;
        end
    endfunction

    function automatic logic [1:0] sort_kind(input logic [2:0] pol);
        logic [1:0] k;
        begin
            case (pol)
                POL_SJF, POL_SJF_PRE:   k = KEY_BURST;
                POL_PRIO, POL_PRIO_PRE: k = KEY_PRIO;
                POL_LONG_IO:            k = KEY_IO;
                default:                k = KEY_FCFS;
            endcase
            return k;
        end
    endfunction

    // true when a is served ahead of b
    function automatic logic ahead_of(input logic [1:0] kind, input rdy_t a, input rdy_t b);
        logic r;
        begin
            r = (a.id < b.id);
            case (kind)
                KEY_PRIO:
                begin
                    if (a.prio != b.prio)
                        r = (a.prio < b.prio);
                    else if (a.cpu != b.cpu)
                        r = (a.cpu < b.cpu);
                end
                KEY_IO:
                begin
                    if (a.io != b.io)
                        r = (a.io > b.io);
                end
                default:
                begin
                    if (a.cpu != b.cpu)
                        r = (a.cpu < b.cpu);
                end
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

@@ sv/cpu_process_scheduler_tick.sv @@
`default_nettype none
// Tick-driven CPU scheduler. A load transaction (tuser 0) places a process in the
// arrival-ordered job queue; a duplicate id is dropped. A tick transaction (tuser 1)
// produces one result in the output register after admitting the arrived jobs,
// stepping the processes in I/O, sorting the ready queue (never for FCFS and round
// robin, at most twice otherwise), running the chosen process and charging the
// ready queue entries. A full output register holds the result back until it is
// taken. The single record memory is read, updated and written back for each
// process, and each sort runs sixteen odd-even phases. A stopped or empty
// scheduler answers a tick straight from the idle state. The next transaction is
// taken once the result sits in the output register.
module cpu_process_scheduler_tick
    import cps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // proc_id[3:0], arrive_tick[11:4], cpu_burst[19:12], io_burst[27:20],
    // io_point[35:28], prio_level[43:36], zero fill
    input  wire logic [47:0] s_axis_tdata,
    // mode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tick_time[15:0], run_valid[16], run_id[20:17], done_valid[21],
    // done_id[25:22], done_turnaround[41:26], done_waiting[57:42],
    // all_done[58], zero fill
    output logic [63:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    state_t state_reg, state_next;
    logic [2:0]  policy_reg, policy_next;
    logic [7:0]  quantum_reg, quantum_next;
    logic [15:0] limit_reg, limit_next;
    logic [15:0] now_reg, now_next;
    logic [MAX_PROCS-1:0] held_reg, held_next;
    logic [MAX_PROCS-1:0] back_reg, back_next;
    job_t        job_q_reg [MAX_PROCS];
    job_t        job_q_next [MAX_PROCS];
    logic [CNT_W-1:0] jn_reg, jn_next;
    rdy_t        rq_reg [MAX_PROCS];
    rdy_t        rq_next [MAX_PROCS];
    logic [CNT_W-1:0] rn_reg, rn_next;
    logic [ID_W-1:0] io_q_reg [MAX_PROCS];
    logic [ID_W-1:0] io_q_next [MAX_PROCS];
    logic [CNT_W-1:0] ion_reg, ion_next;
    logic        run_on_reg, run_on_next;
    rdy_t        run_reg, run_next;
    logic [7:0]  slice_reg, slice_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] nn_reg, nn_next;
    logic [1:0]  ph_reg, ph_next;
    logic [3:0]  sort_cnt_reg, sort_cnt_next;
    logic        stop_reg, stop_next;
    logic        tdone_reg, tdone_next;
    logic        tio_reg, tio_next;
    result_t     res_reg, res_next;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    // record memory
    rec_t        rec_mem [MAX_PROCS];
    rec_t        rd_data_reg;
    logic        mem_we;
    logic [ID_W-1:0] mem_waddr, mem_raddr;
    rec_t        mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            rec_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= rec_mem[mem_raddr];
    end

    // load fields
    logic [ID_W-1:0] ld_id;
    job_t            ld_job;
    logic [MAX_PROCS-1:0] ld_keep;
    assign ld_id = s_axis_tdata[3:0];

    always_comb
    begin
        ld_job.arr      = s_axis_tdata[11:4];
        ld_job.key.id   = ld_id;
        ld_job.key.cpu  = s_axis_tdata[19:12];
        ld_job.key.io   = s_axis_tdata[27:20];
        ld_job.key.prio = s_axis_tdata[43:36];
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            ld_keep[i] = (CNT_W'(i) < jn_reg) &&
                ((job_q_reg[i].arr < ld_job.arr) ||
                 ((job_q_reg[i].arr == ld_job.arr) && (job_q_reg[i].key.id < ld_id)));
        end
    end

    logic [1:0] kind;
    assign kind = sort_kind(policy_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.all_done, out_reg.done_waiting,
                            out_reg.done_turnaround, out_reg.done_id, out_reg.done_valid,
                            out_reg.run_id, out_reg.run_valid, out_reg.tick_time};

    // sequencer
    always_comb
    begin
        rec_t        r;
        logic [ID_W-1:0] id;
        logic [15:0] nowp;
        logic        empty;
        logic        better;
        logic [CNT_W-1:0] last;

        state_next     = state_reg;
        policy_next    = policy_reg;
        quantum_next   = quantum_reg;
        limit_next     = limit_reg;
        now_next       = now_reg;
        held_next      = held_reg;
        back_next      = back_reg;
        job_q_next     = job_q_reg;
        jn_next        = jn_reg;
        rq_next        = rq_reg;
        rn_next        = rn_reg;
        io_q_next      = io_q_reg;
        ion_next       = ion_reg;
        run_on_next    = run_on_reg;
        run_next       = run_reg;
        slice_next     = slice_reg;
        idx_next       = idx_reg;
        nn_next        = nn_reg;
        ph_next        = ph_reg;
        sort_cnt_next  = sort_cnt_reg;
        stop_next      = stop_reg;
        tdone_next     = tdone_reg;
        tio_next       = tio_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = rd_data_reg;
        mem_raddr      = '0;
        r              = rd_data_reg;
        id             = '0;
        nowp           = now_reg + 16'd1;
        empty          = (jn_reg == '0) && (rn_reg == '0) && (ion_reg == '0) && !run_on_reg;
        better         = 1'b0;
        last           = rn_reg - CNT_W'(1);

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLICY:     policy_next  = cfg_data[2:0];
                CFG_QUANTUM:    quantum_next = cfg_data[7:0];
                CFG_TICK_LIMIT: limit_next   = cfg_data;
                default:        ;
            endcase
        end

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == MODE_LOAD)
                    begin
                        if (!held_reg[ld_id])
                        begin
                            held_next[ld_id] = 1'b1;
                            mem_we           = 1'b1;
                            mem_waddr        = ld_id;
                            mem_wdata.cpu      = ld_job.key.cpu;
                            mem_wdata.io       = ld_job.key.io;
                            mem_wdata.trig     = s_axis_tdata[35:28];
                            mem_wdata.prio     = ld_job.key.prio;
                            mem_wdata.wait_cnt = '0;
                            mem_wdata.turn_cnt = '0;
                            // sorted insert by arrival, then id
                            if (!ld_keep[0])
                                job_q_next[0] = ld_job;
                            for (int i = 1; i < MAX_PROCS; i++)
                            begin
                                if (!ld_keep[i])
                                begin
                                    if (ld_keep[i-1])
                                        job_q_next[i] = ld_job;
                                    else
                                        job_q_next[i] = job_q_reg[i-1];
                                end
                            end
                            jn_next = jn_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        res_next = '0;
                        if ((now_reg >= limit_reg) || empty)
                        begin
                            stop_next  = 1'b1;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            stop_next  = 1'b0;
                            state_next = ST_ADMIT;
                        end
                    end
                end
            end

            // move arrived jobs to the ready tail, one per cycle
            ST_ADMIT:
            begin
                if ((jn_reg != '0) && ({8'd0, job_q_reg[0].arr} <= now_reg))
                begin
                    rq_next[rn_reg[ID_W-1:0]] = job_q_reg[0].key;
                    rn_next = rn_reg + CNT_W'(1);
                    for (int i = 0; i < MAX_PROCS - 1; i++)
                        job_q_next[i] = job_q_reg[i+1];
                    jn_next = jn_reg - CNT_W'(1);
                end
                else
                begin
                    back_next  = '0;
                    idx_next   = '0;
                    nn_next    = '0;
                    state_next = ST_IO_RD;
                end
            end

            // i/o countdown scan
            ST_IO_RD:
            begin
                if (idx_reg < ion_reg)
                begin
                    mem_raddr  = io_q_reg[idx_reg[ID_W-1:0]];
                    state_next = ST_IO_WR;
                end
                else
                begin
                    ion_next   = nn_reg;
                    ph_next    = '0;
                    state_next = ST_PICK;
                end
            end

            ST_IO_WR:
            begin
                id = io_q_reg[idx_reg[ID_W-1:0]];
                if (r.io != 8'd0)
                    r.io = r.io - 8'd1;
                if (r.io != 8'd0)
                begin
                    r.turn_cnt = sat_inc(r.turn_cnt);
                    io_q_next[nn_reg[ID_W-1:0]] = id;
                    nn_next = nn_reg + CNT_W'(1);
                end
                else
                begin
                    back_next[id] = 1'b1;
                    rq_next[rn_reg[ID_W-1:0]] = '{id: id, cpu: r.cpu, prio: r.prio, io: 8'd0};
                    rn_next = rn_reg + CNT_W'(1);
                end
                mem_we     = 1'b1;
                mem_waddr  = id;
                mem_wdata  = r;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_IO_RD;
            end

            // policy decision
            ST_PICK:
            begin
                state_next = ST_RUN_RD;
                case (policy_reg)
                    POL_FCFS:
                    begin
                        if (!run_on_reg && (rn_reg != '0))
                        begin
                            run_next    = rq_reg[0];
                            run_on_next = 1'b1;
                            for (int i = 0; i < MAX_PROCS - 1; i++)
                                rq_next[i] = rq_reg[i+1];
                            rn_next = rn_reg - CNT_W'(1);
                        end
                    end
                    POL_SJF, POL_PRIO, POL_LONG_IO, POL_SJF_PRE, POL_PRIO_PRE:
                    begin
                        case (ph_reg)
                            2'd0:
                            begin
                                if ((rn_reg != '0) && (!run_on_reg ||
                                    (policy_reg == POL_SJF_PRE) || (policy_reg == POL_PRIO_PRE)))
                                begin
                                    ph_next       = 2'd1;
                                    sort_cnt_next = '0;
                                    state_next    = ST_SORT;
                                end
                            end
                            2'd1:
                            begin
                                if (!run_on_reg)
                                begin
                                    run_next    = rq_reg[0];
                                    run_on_next = 1'b1;
                                    for (int i = 0; i < MAX_PROCS - 1; i++)
                                        rq_next[i] = rq_reg[i+1];
                                    rn_next = rn_reg - CNT_W'(1);
                                end
                                else
                                begin
                                    if (policy_reg == POL_PRIO_PRE)
                                        better = (rq_reg[0].prio < run_reg.prio);
                                    else
                                        better = (rq_reg[0].cpu < run_reg.cpu);
                                    if (better)
                                    begin
                                        rq_next[rn_reg[ID_W-1:0]] = run_reg;
                                        rn_next       = rn_reg + CNT_W'(1);
                                        ph_next       = 2'd2;
                                        sort_cnt_next = '0;
                                        state_next    = ST_SORT;
                                    end
                                end
                            end
                            default:
                            begin
                                run_next = rq_reg[0];
                                for (int i = 0; i < MAX_PROCS - 1; i++)
                                    rq_next[i] = rq_reg[i+1];
                                rn_next = rn_reg - CNT_W'(1);
                            end
                        endcase
                    end
                    POL_RR:
                    begin
                        if (ph_reg == 2'd0)
                        begin
                            if (!run_on_reg && (rn_reg != '0))
                            begin
                                run_next    = rq_reg[0];
                                run_on_next = 1'b1;
                                slice_next  = '0;
                                for (int i = 0; i < MAX_PROCS - 1; i++)
                                    rq_next[i] = rq_reg[i+1];
                                rn_next = rn_reg - CNT_W'(1);
                            end
                            ph_next    = 2'd1;
                            state_next = ST_PICK;
                        end
                        else if (run_on_reg)
                        begin
                            if (slice_reg >= quantum_reg)
                            begin
                                // rotate the running process to the tail
                                if (rn_reg != '0)
                                begin
                                    run_next = rq_reg[0];
                                    for (int i = 0; i < MAX_PROCS - 1; i++)
                                        rq_next[i] = rq_reg[i+1];
                                    rq_next[last[ID_W-1:0]] = run_reg;
                                end
                                slice_next = 8'd1;
                            end
                            else
                                slice_next = slice_reg + 8'd1;
                        end
                    end
                    default: ;
                endcase
            end

            // odd-even transposition phase over the ready queue
            ST_SORT:
            begin
                for (int i = 0; i < MAX_PROCS - 1; i++)
                begin
                    if ((i % 2 == int'(sort_cnt_reg[0])) && (CNT_W'(i + 1) < rn_reg) &&
                        ahead_of(kind, rq_reg[i+1], rq_reg[i]))
                    begin
                        rq_next[i]   = rq_reg[i+1];
                        rq_next[i+1] = rq_reg[i];
                    end
                end
                sort_cnt_next = sort_cnt_reg + 4'd1;
                if (sort_cnt_reg == 4'(MAX_PROCS - 1))
                    state_next = ST_PICK;
            end

            // run the chosen process for one unit
            ST_RUN_RD:
            begin
                if (run_on_reg)
                begin
                    mem_raddr  = run_reg.id;
                    state_next = ST_RUN_WR;
                end
                else
                    state_next = ST_FIN;
            end

            ST_RUN_WR:
            begin
                if (r.cpu != 8'd0)
                    r.cpu = r.cpu - 8'd1;
                r.turn_cnt   = sat_inc(r.turn_cnt);
                mem_we       = 1'b1;
                mem_waddr    = run_reg.id;
                mem_wdata    = r;
                run_next.cpu = r.cpu;
                res_next.run_valid = 1'b1;
                res_next.run_id    = run_reg.id;
                tdone_next = (r.cpu == 8'd0) && (r.io == 8'd0);
                tio_next   = (r.io != 8'd0) && ((r.cpu == 8'd0) || (r.trig == r.cpu));
                if ((r.cpu == 8'd0) && (r.io == 8'd0))
                begin
                    res_next.done_valid      = 1'b1;
                    res_next.done_id         = run_reg.id;
                    res_next.done_turnaround = r.turn_cnt;
                    res_next.done_waiting    = r.wait_cnt;
                end
                idx_next   = '0;
                state_next = ST_CHG_RD;
            end

            // charge waiting and turnaround to ready entries
            ST_CHG_RD:
            begin
                if (idx_reg < rn_reg)
                begin
                    mem_raddr  = rq_reg[idx_reg[ID_W-1:0]].id;
                    state_next = ST_CHG_WR;
                end
                else
                begin
                    if (tdone_reg || tio_reg)
                        run_on_next = 1'b0;
                    if (tio_reg)
                    begin
                        io_q_next[ion_reg[ID_W-1:0]] = run_reg.id;
                        ion_next = ion_reg + CNT_W'(1);
                    end
                    if (tdone_reg)
                        held_next[run_reg.id] = 1'b0;
                    state_next = ST_FIN;
                end
            end

            ST_CHG_WR:
            begin
                id = rq_reg[idx_reg[ID_W-1:0]].id;
                if (!back_reg[id])
                    r.wait_cnt = sat_inc(r.wait_cnt);
                r.turn_cnt = sat_inc(r.turn_cnt);
                mem_we     = 1'b1;
                mem_waddr  = id;
                mem_wdata  = r;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_CHG_RD;
            end

            // hand the result to the output register
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (stop_reg)
                    begin
                        out_next           = '0;
                        out_next.tick_time = now_reg;
                        out_next.all_done  = 1'b1;
                    end
                    else
                    begin
                        out_next           = res_reg;
                        out_next.tick_time = now_reg;
                        out_next.all_done  = empty || (nowp >= limit_reg);
                        now_next           = nowp;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            policy_reg    <= POL_FCFS;
            quantum_reg   <= 8'd5;
            limit_reg     <= 16'd100;
            now_reg       <= '0;
            held_reg      <= '0;
            jn_reg        <= '0;
            rn_reg        <= '0;
            ion_reg       <= '0;
            run_on_reg    <= 1'b0;
            slice_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            quantum_reg   <= quantum_next;
            limit_reg     <= limit_next;
            now_reg       <= now_next;
            held_reg      <= held_next;
            jn_reg        <= jn_next;
            rn_reg        <= rn_next;
            ion_reg       <= ion_next;
            run_on_reg    <= run_on_next;
            slice_reg     <= slice_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        back_reg     <= back_next;
        job_q_reg    <= job_q_next;
        rq_reg       <= rq_next;
        io_q_reg     <= io_q_next;
        run_reg      <= run_next;
        idx_reg      <= idx_next;
        nn_reg       <= nn_next;
        ph_reg       <= ph_next;
        sort_cnt_reg <= sort_cnt_next;
        stop_reg     <= stop_next;
        tdone_reg    <= tdone_next;
        tio_reg      <= tio_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule
`default_nettype wire
